@@ rtl/core/id_membership_set_unit_macros.svh @@
// ----------------------------------------------------------------------------
// id membership set assertion macros
// shared assertion forms for the set unit, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ID_MEMBERSHIP_SET_UNIT_MACROS_SVH
`define ID_MEMBERSHIP_SET_UNIT_MACROS_SVH

// same-cycle implication
`define IDMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id set check failed");

// next-cycle implication
`define IDMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id set sequencing check failed");

`endif

@@ rtl/core/idms_pkg.sv @@
// ----------------------------------------------------------------------------
// idms_pkg
// operation codes and fixed field widths of the id membership set unit
// ----------------------------------------------------------------------------
`default_nettype none

package idms_pkg;

  localparam int ID_W    = 32;
  localparam int IDX_W   = 8;
  localparam int TOTAL_W = 9;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef logic [ID_W-1:0] id_t;

endpackage

`default_nettype wire

@@ rtl/core/idms_ram.sv @@
// ----------------------------------------------------------------------------
// idms_ram
// single write port, single read port member store with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module idms_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire idms_pkg::id_t   wdata,
  input  wire logic [AW-1:0]   raddr,
  output idms_pkg::id_t        rdata
);
  import idms_pkg::*;

  id_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/id_membership_set_unit.sv @@
// ----------------------------------------------------------------------------
// id_membership_set_unit
// packed set of 32-bit ids with lookup, add, remove with compaction and read
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   item     item_valid / item_stall   operation, item_id, entry_index
//   result   result_valid/result_stall was_member, refused_full, entry_value,
//                                      entry_valid, member_total
//
// each word scans the stored ids in order, a read state then a compare state per
// entry through the one read port and shared compare, stopping at the first match;
// remove then shifts each later entry down, a read then a write, and a live read
// adds a fetch wait state; no new word is taken until the unit is back in idle
// after reset the set is empty; a stalled result waits in its output register
// and holds only the finish step of the next word, not its acceptance
// ----------------------------------------------------------------------------
`default_nettype none

module id_membership_set_unit #(
  parameter int CAPACITY = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output      logic                          item_stall,
  input  wire idms_pkg::op_t                 operation,
  input  wire idms_pkg::id_t                 item_id,
  input  wire logic [idms_pkg::IDX_W-1:0]    entry_index,
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic                          was_member,
  output      logic                          refused_full,
  output      idms_pkg::id_t                 entry_value,
  output      logic                          entry_valid,
  output      logic [idms_pkg::TOTAL_W-1:0]  member_total
);
  import idms_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SCAN_RD    = 8'b0000_0010,
    S_SCAN_CMP   = 8'b0000_0100,
    S_DECIDE     = 8'b0000_1000,
    S_SHIFT_RD   = 8'b0001_0000,
    S_SHIFT_WR   = 8'b0010_0000,
    S_FETCH_WAIT = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // latched word
  op_t              op_reg;
  id_t              id_reg;
  logic [IDX_W-1:0] idx_reg;

  logic [CW-1:0] total, total_next;
  logic [CW-1:0] ptr, ptr_next;
  logic          found, found_next;
  logic          refused, refused_next;
  logic          rd_ok, rd_ok_next;
  id_t           value, value_next;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  id_t           ram_wdata;
  logic [AW-1:0] ram_raddr;
  id_t           ram_rdata;

  logic [CW:0]       ptr_inc;
  logic [CW+IDX_W-1:0] idx_wide;
  logic [CW+IDX_W-1:0] total_wide;
  logic [CW+TOTAL_W-1:0] total_out;
  logic              id_match;
  logic              accept_item;
  logic              result_free;

  idms_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_stall  = (state != S_IDLE);
  assign accept_item = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;

  assign ptr_inc    = {1'b0, ptr} + (CW+1)'(1);
  assign idx_wide   = {{CW{1'b0}}, idx_reg};
  assign total_wide = {{IDX_W{1'b0}}, total};
  assign total_out  = {{TOTAL_W{1'b0}}, total};
  // the one shared compare unit
  assign id_match   = (ram_rdata == id_reg);

  always_comb begin
    state_next   = state;
    total_next   = total;
    ptr_next     = ptr;
    found_next   = found;
    refused_next = refused;
    rd_ok_next   = rd_ok;
    value_next   = value;
    ram_we       = 1'b0;
    ram_waddr    = total[AW-1:0];
    ram_wdata    = id_reg;
    ram_raddr    = ptr[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept_item) begin
          ptr_next     = '0;
          found_next   = 1'b0;
          refused_next = 1'b0;
          rd_ok_next   = 1'b0;
          value_next   = '0;
          state_next   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (ptr == total) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (id_match) begin
          // ptr stays on the hit, remove starts from there
          found_next = 1'b1;
          state_next = S_DECIDE;
        end else begin
          ptr_next   = ptr_inc[CW-1:0];
          state_next = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        case (op_reg)
          OP_ADD: begin
            if (!found) begin
              if (total < CW'(CAPACITY)) begin
                ram_we     = 1'b1;
                total_next = total + CW'(1);
              end else begin
                refused_next = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (found) begin
              state_next = S_SHIFT_RD;
            end
          end
          OP_READ: begin
            if (idx_wide < total_wide) begin
              ram_raddr  = idx_wide[AW-1:0];
              rd_ok_next = 1'b1;
              state_next = S_FETCH_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (ptr_inc >= {1'b0, total}) begin
          total_next = total - CW'(1);
          state_next = S_DONE;
        end else begin
          ram_raddr  = ptr_inc[AW-1:0];
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = ptr[AW-1:0];
        ram_wdata  = ram_rdata;
        ptr_next   = ptr_inc[CW-1:0];
        state_next = S_SHIFT_RD;
      end
      S_FETCH_WAIT: begin
        value_next = ram_rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (result_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      if ((state == S_DONE) && result_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    found   <= found_next;
    refused <= refused_next;
    rd_ok   <= rd_ok_next;
    value   <= value_next;
    if (accept_item) begin
      op_reg  <= operation;
      id_reg  <= item_id;
      idx_reg <= entry_index;
    end
    if ((state == S_DONE) && result_free) begin
      was_member   <= found;
      refused_full <= refused;
      entry_value  <= value;
      entry_valid  <= rd_ok;
      member_total <= total_out[TOTAL_W-1:0];
    end
  end

`include "id_membership_set_unit_macros.svh"

  `IDMS_ASSERT_NOW(a_total_bound, 1'b1, total <= CW'(CAPACITY))
  `IDMS_ASSERT_NOW(a_refuse_only_absent, result_valid, !(refused_full && was_member))
  `IDMS_ASSERT_NOW(a_read_not_refused, result_valid && entry_valid, !refused_full)
  `IDMS_ASSERT_NEXT(a_accept_starts_scan, accept_item, state == S_SCAN_RD)

endmodule

`default_nettype wire

@@ tb/id_membership_set_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_membership_set_checker
// watches both channels of the id set unit, keeps its own packed copy of the
// set, predicts each result word from every accepted item word and compares
// the result words in order, field by field
// ----------------------------------------------------------------------------

module id_membership_set_checker #(
  parameter int CAPACITY = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  input  wire logic                             item_stall,
  input  wire idms_pkg::op_t                    operation,
  input  wire idms_pkg::id_t                    item_id,
  input  wire logic [idms_pkg::IDX_W-1:0]       entry_index,
  input  wire logic                             result_valid,
  input  wire logic                             result_stall,
  input  wire logic                             was_member,
  input  wire logic                             refused_full,
  input  wire idms_pkg::id_t                    entry_value,
  input  wire logic                             entry_valid,
  input  wire logic [idms_pkg::TOTAL_W-1:0]     member_total,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    checked_count,
  output int                                    refusal_count,
  output int                                    peak_total
);
  import idms_pkg::*;

  typedef struct packed {
    logic               was_member;
    logic               refused_full;
    id_t                entry_value;
    logic               entry_valid;
    logic [TOTAL_W-1:0] member_total;
  } set_result_t;

  set_result_t expected_results[$];
  set_result_t want;
  id_t         stored_ids [CAPACITY];
  int unsigned stored_count;

  // applies one operation to the shadow set and returns the result word
  function automatic set_result_t apply_word(op_t op, id_t id, logic [IDX_W-1:0] idx);
    set_result_t r;
    int unsigned pos;
    r = '0;
    pos = stored_count;
    for (int unsigned i = 0; i < stored_count; i++) begin
      if (pos == stored_count && stored_ids[i] == id) pos = i;
    end
    r.was_member = (pos < stored_count);
    case (op)
      OP_ADD: begin
        if (!r.was_member) begin
          if (stored_count < CAPACITY) begin
            stored_ids[stored_count] = id;
            stored_count++;
          end else begin
            r.refused_full = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (r.was_member) begin
          // close the gap, keeping insertion order
          for (int unsigned j = pos; j + 1 < stored_count; j++) stored_ids[j] = stored_ids[j + 1];
          stored_count--;
        end
      end
      OP_READ: begin
        if (idx < stored_count) begin
          r.entry_value = stored_ids[idx];
          r.entry_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.member_total = TOTAL_W'(stored_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stored_count = 0;
      expected_results.delete();
    end else begin
      // a result word never belongs to the item word taken on the same edge
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with no item word outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("was_member", 32'(want.was_member), 32'(was_member));
          check_field("refused_full", 32'(want.refused_full), 32'(refused_full));
          check_field("entry_value", want.entry_value, entry_value);
          check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid));
          check_field("member_total", 32'(want.member_total), 32'(member_total));
          checked_count++;
        end
      end
      if (item_valid && !item_stall) begin
        want = apply_word(operation, item_id, entry_index);
        expected_results.insert(expected_results.size(), want);
        if (want.refused_full) refusal_count++;
        if (int'(stored_count) > peak_total) peak_total = int'(stored_count);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/id_membership_set_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_membership_set_unit_tb
// drives lookup, add, remove and read words into the id set unit: a directed
// pass over the corner cases, random traffic on a small id pool, a fill to
// capacity with refused adds and a full drain, under three idling mixes
// ----------------------------------------------------------------------------

module id_membership_set_unit_tb;
  import idms_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int POOL_SIZE    = 40;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 32;

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  op_t                operation    = OP_LOOKUP;
  id_t                item_id      = '0;
  logic [IDX_W-1:0]   entry_index  = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               was_member;
  logic               refused_full;
  id_t                entry_value;
  logic               entry_valid;
  logic [TOTAL_W-1:0] member_total;

  int fail_count, pending, checked_count, refusal_count, peak_total;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;
  int words_sent    = 0;

  id_t id_pool [POOL_SIZE];
  id_t fill_ids[$];

  id_membership_set_unit #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .item_id      (item_id),
    .entry_index  (entry_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .was_member   (was_member),
    .refused_full (refused_full),
    .entry_value  (entry_value),
    .entry_valid  (entry_valid),
    .member_total (member_total)
  );

  id_membership_set_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .item_id       (item_id),
    .entry_index   (entry_index),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .was_member    (was_member),
    .refused_full  (refused_full),
    .entry_value   (entry_value),
    .entry_valid   (entry_valid),
    .member_total  (member_total),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .refusal_count (refusal_count),
    .peak_total    (peak_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) result_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("run timed out after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_word(op_t op, id_t id, logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    operation   <= op;
    item_id     <= id;
    entry_index <= idx;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic id_t pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return id_t'($urandom);
  endfunction

  task automatic push_random_word();
    op_t              op;
    int               pick;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = OP_LOOKUP;
    else if (pick < 55) op = OP_ADD;
    else if (pick < 80) op = OP_REMOVE;
    else                op = OP_READ;
    // reads mostly land near the live entries
    if ($urandom_range(0, 99) < 70) idx = IDX_W'($urandom_range(0, 31));
    else                            idx = IDX_W'($urandom);
    push_word(op, pick_id(), idx);
  endtask

  // sender holds off until every result word is back
  task automatic settle();
    item_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    id_t fresh;
    int  k;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = id_t'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 69;

    // empty set: lookup, read and remove find nothing
    push_word(OP_LOOKUP, 32'h0000_0000, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd0);
    push_word(OP_REMOVE, 32'h0000_0005, 8'hff);
    push_word(OP_ADD,    32'h0000_0000, 8'd0);
    push_word(OP_ADD,    32'hffff_ffff, 8'hff);
    // add of a present id leaves the set alone and is not refused
    push_word(OP_ADD,    32'h0000_0000, 8'd0);
    push_word(OP_ADD,    32'h1234_5678, 8'd0);
    push_word(OP_ADD,    32'ha5a5_5a5a, 8'd0);
    push_word(OP_LOOKUP, 32'hffff_ffff, 8'd0);
    push_word(OP_LOOKUP, 32'h0000_0001, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd3);
    // reads at or past the count
    push_word(OP_READ,   32'h0000_0000, 8'd4);
    push_word(OP_READ,   32'hffff_ffff, 8'hff);
    // middle, last and first removes
    push_word(OP_REMOVE, 32'hffff_ffff, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd1);
    push_word(OP_READ,   32'h0000_0000, 8'd2);
    push_word(OP_REMOVE, 32'ha5a5_5a5a, 8'd0);
    push_word(OP_REMOVE, 32'h0000_0000, 8'd0);
    push_word(OP_REMOVE, 32'h0000_0007, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd0);
    push_word(OP_LOOKUP, 32'h1234_5678, 8'd0);
    push_word(OP_REMOVE, 32'h1234_5678, 8'd0);
    push_word(OP_READ,   32'h0000_0000, 8'd0);
    settle();

    repeat (200) push_random_word();
    settle();

    send_idle_pct = 69;
    recv_idle_pct = 31;
    repeat (150) push_random_word();

    // fill past capacity so the tail of the adds gets refused
    repeat (CAPACITY + 14) begin
      fresh = id_t'($urandom);
      fill_ids.insert(fill_ids.size(), fresh);
      push_word(OP_ADD, fresh, IDX_W'($urandom));
    end
    repeat (30) begin
      case ($urandom_range(0, 3))
        0: push_word(OP_LOOKUP, fill_ids[$urandom_range(0, fill_ids.size() - 1)], 8'd0);
        1: push_word(OP_ADD, id_t'($urandom), IDX_W'($urandom));
        2: push_word(OP_READ, pick_id(), IDX_W'($urandom));
        default: push_word(OP_ADD, fill_ids[$urandom_range(0, 40)], 8'd0);
      endcase
    end
    // drain in random order so compaction shifts run long and short
    while (fill_ids.size() > 0) begin
      k = $urandom_range(0, fill_ids.size() - 1);
      push_word(OP_REMOVE, fill_ids[k], IDX_W'($urandom));
      fill_ids.delete(k);
    end
    for (int i = 0; i < POOL_SIZE; i++) push_word(OP_REMOVE, id_pool[i], IDX_W'($urandom));
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) push_random_word();
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d item words in %0d cycles with %0d result words checked",
             words_sent, cycle_count, checked_count);
    $display("set peaked at %0d members and %0d adds were refused as full",
             peak_total, refusal_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
